// ===== design/lscmp_pkg.sv =====
// Shared types and constants for the letter shift count matrix power block.
package lscmp_pkg;

  localparam int VAL_W    = 30;
  localparam int ROUNDS_W = 31;
  localparam int LETTER_W = 5;
  localparam int CNT_IN_W = 5;

  localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  typedef enum logic [1:0] {
    OP_BUILD,
    OP_MUL,
    OP_COPY,
    OP_SUM
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   src_p;
    logic   dst_p;
    logic   clr;
    logic   issue;
    logic   adv_k;
    logic   adv_ent;
    logic   last_tag;
    logic   hist_rd;
    logic   hist_wr;
    logic   hist_clr;
    logic   shift_wr;
    logic   s_write;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic k_last;
    logic ent_last;
    logic red_ready;
  } dp_stat_t;

endpackage

// ===== design/lscmp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lscmp_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 676
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lscmp_dp.sv =====
// Datapath: tables, matrix memories, modular multiply-accumulate and reducer.
module lscmp_dp import lscmp_pkg::*; #(
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  input  logic [LETTER_W-1:0] in_letter_index,
  input  logic [CNT_IN_W-1:0] in_shift_count,
  output logic [VAL_W-1:0]    total_length
);

  localparam int LW    = $clog2(ALPHABET);
  localparam int CELLS = ALPHABET * ALPHABET;
  localparam int MW    = $clog2(CELLS);
  localparam int SW    = $clog2(ALPHABET + 1);
  localparam int XW    = ((LW > LETTER_W) ? LW : LETTER_W) + 1;
  localparam int CW    = (SW > CNT_IN_W) ? SW : CNT_IN_W;
  localparam int BW    = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
  localparam int PW    = VAL_W + BW;
  localparam int ACC_W = PW + MW;
  localparam int YW    = 2 * VAL_W - 2;
  localparam int L2W   = ACC_W - 2 * VAL_W;
  localparam int QSH   = VAL_W - 2;
  localparam int QOUT  = VAL_W + 2;

  localparam logic [63:0] PRIME_64 = 64'(PRIME);
  localparam logic [63:0] FOLD1    = (64'd1 << VAL_W) % PRIME_64;
  localparam logic [63:0] FOLD2    = (FOLD1 * FOLD1) % PRIME_64;
  localparam logic [63:0] MU       = (64'd1 << (2 * VAL_W)) / PRIME_64;

  localparam logic [LW-1:0] LAST_IDX = LW'(ALPHABET - 1);

  dp_op_t          op_r;
  logic            src_p_r;
  logic            dst_p_r;
  logic [LW-1:0]   r_cnt_r, c_cnt_r, k_cnt_r;
  logic [MW-1:0]   ent_addr, rk_addr, kc_addr;
  logic [LW:0]     diff_w;

  logic            v1_r, v2_r;
  logic [MW-1:0]   ent1_r;
  logic            diag1_r;
  logic [LW-1:0]   diff1_r;
  logic            last1_r, last2_r;
  logic [PW-1:0]   prod2_r;

  logic [VAL_W-1:0] p_rd, b1_rd, b2_rd, s_rd;
  logic [SW-1:0]    shift_rd;
  logic [COUNT_BITS-1:0] hist_rd;

  logic             mat_bld, mat_copy, mac_op;
  logic             p_we, b_we;
  logic [VAL_W-1:0] p_wdata, b_wdata;
  logic [MW-1:0]    p_raddr;
  logic [SW-1:0]    cnt_eff;
  logic             bld_bit;

  logic [XW-1:0]    let_x;
  logic             let_rng;
  logic [LW-1:0]    let_addr;
  logic [CW-1:0]    cnt_x, cnt_clamp;
  logic [LW-1:0]    let_r;
  logic             let_rng_r;
  logic [LW-1:0]    hist_raddr;
  logic [COUNT_BITS-1:0] hist_inc;
  logic [ALPHABET-1:0] hv_r, sv_r;
  logic             hv1_r, sv1_r;

  logic [VAL_W-1:0] a_op;
  logic [BW-1:0]    b_op;
  logic [PW-1:0]    prod;
  logic [ACC_W-1:0] acc_r, acc_sum;

  logic [4:0]           red_pipe_r;
  logic                 red_done_r;
  logic [ACC_W-1:0]     red_x_r;
  logic [VAL_W-1:0]     red_l0_r;
  logic [2*VAL_W-1:0]   red_p1;
  logic [L2W+VAL_W-1:0] red_p2;
  logic [YW-1:0]        red_p1_r, red_p2_r, red_y_r;
  logic [2*VAL_W:0]     red_qm;
  logic [VAL_W-1:0]     red_q_r;
  logic [2*VAL_W-1:0]   red_qp;
  logic [YW-1:0]        red_rem;
  logic [VAL_W+1:0]     red_rem_r, red_m1, red_m2;
  logic [VAL_W-1:0]     red_r, red_nx;
  logic [VAL_W-1:0]     res_r;

  // Addressing
  assign ent_addr = MW'(r_cnt_r) * MW'(ALPHABET) + MW'(c_cnt_r);
  assign rk_addr  = MW'(r_cnt_r) * MW'(ALPHABET) + MW'(k_cnt_r);
  assign kc_addr  = MW'(k_cnt_r) * MW'(ALPHABET) + MW'(c_cnt_r);
  assign p_raddr  = (op_r == OP_SUM) ? ent_addr : rk_addr;

  // Distance from column letter to row letter, modulo the alphabet
  assign diff_w = (r_cnt_r >= c_cnt_r) ? ({1'b0, r_cnt_r} - {1'b0, c_cnt_r})
                : ({1'b0, r_cnt_r} + (LW+1)'(ALPHABET) - {1'b0, c_cnt_r});

  assign stat.k_last    = (k_cnt_r == LAST_IDX);
  assign stat.ent_last  = (r_cnt_r == LAST_IDX) && (c_cnt_r == LAST_IDX);
  assign stat.red_ready = red_done_r;

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      op_r    <= cmd.op;
      src_p_r <= cmd.src_p;
      dst_p_r <= cmd.dst_p;
      r_cnt_r <= '0;
      c_cnt_r <= '0;
      k_cnt_r <= '0;
    end else begin
      if (cmd.adv_k) begin
        k_cnt_r <= (k_cnt_r == LAST_IDX) ? '0 : k_cnt_r + LW'(1);
      end
      if (cmd.adv_ent) begin
        if (c_cnt_r == LAST_IDX) begin
          c_cnt_r <= '0;
          r_cnt_r <= (r_cnt_r == LAST_IDX) ? '0 : r_cnt_r + LW'(1);
        end else begin
          c_cnt_r <= c_cnt_r + LW'(1);
        end
      end
    end
  end

  // Pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r && mac_op;
    end
  end

  always_ff @(posedge clk) begin
    ent1_r  <= ent_addr;
    diag1_r <= (r_cnt_r == c_cnt_r);
    diff1_r <= diff_w[LW-1:0];
    last1_r <= cmd.last_tag;
    last2_r <= last1_r;
    prod2_r <= prod;
  end

  // Matrix writes land in the cycle after issue
  assign mat_bld  = v1_r && (op_r == OP_BUILD);
  assign mat_copy = v1_r && (op_r == OP_COPY);
  assign mac_op   = (op_r == OP_MUL) || (op_r == OP_SUM);

  // A full count wraps all the way around and marks the diagonal too
  assign cnt_eff = sv1_r ? shift_rd : '0;
  assign bld_bit = (diff1_r == '0) ? (cnt_eff == SW'(ALPHABET))
                 : (SW'(diff1_r) <= cnt_eff);

  assign p_we    = mat_bld || (mat_copy && dst_p_r);
  assign b_we    = mat_bld || (mat_copy && !dst_p_r);
  assign p_wdata = mat_bld ? VAL_W'(diag1_r) : s_rd;
  assign b_wdata = mat_bld ? VAL_W'(bld_bit) : s_rd;

  lscmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(ent1_r), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rd)
  );

  lscmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_b1_ram (
    .clk(clk), .we(b_we), .waddr(ent1_r), .wdata(b_wdata),
    .raddr(rk_addr), .rdata(b1_rd)
  );

  lscmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_b2_ram (
    .clk(clk), .we(b_we), .waddr(ent1_r), .wdata(b_wdata),
    .raddr(kc_addr), .rdata(b2_rd)
  );

  lscmp_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_s_ram (
    .clk(clk), .we(cmd.s_write), .waddr(ent_addr), .wdata(red_r),
    .raddr(ent_addr), .rdata(s_rd)
  );

  // Shift table and histogram
  assign let_x     = XW'(in_letter_index);
  assign let_rng   = (let_x < XW'(ALPHABET));
  assign let_addr  = let_x[LW-1:0];
  assign cnt_x     = CW'(in_shift_count);
  assign cnt_clamp = (cnt_x > CW'(ALPHABET)) ? CW'(ALPHABET) : cnt_x;

  assign hist_raddr = cmd.hist_rd ? let_addr : c_cnt_r;
  assign hist_inc   = (hv1_r ? hist_rd : '0) + COUNT_BITS'(1);

  lscmp_ram #(.WIDTH(SW), .DEPTH(ALPHABET)) u_shift_ram (
    .clk(clk), .we(cmd.shift_wr && let_rng), .waddr(let_addr),
    .wdata(cnt_clamp[SW-1:0]), .raddr(c_cnt_r), .rdata(shift_rd)
  );

  lscmp_ram #(.WIDTH(COUNT_BITS), .DEPTH(ALPHABET)) u_hist_ram (
    .clk(clk), .we(cmd.hist_wr && let_rng_r), .waddr(let_r),
    .wdata(hist_inc), .raddr(hist_raddr), .rdata(hist_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.hist_rd) begin
      let_r     <= let_addr;
      let_rng_r <= let_rng;
    end
    hv1_r <= hv_r[hist_raddr];
    sv1_r <= sv_r[c_cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
      sv_r <= '0;
    end else begin
      if (cmd.hist_clr) begin
        hv_r <= '0;
      end else if (cmd.hist_wr && let_rng_r) begin
        hv_r[let_r] <= 1'b1;
      end
      if (cmd.shift_wr && let_rng) begin
        sv_r[let_addr] <= 1'b1;
      end
    end
  end

  // Multiply-accumulate; the sum stays unreduced until the entry ends
  assign a_op = ((op_r == OP_SUM) || src_p_r) ? p_rd : b1_rd;
  assign b_op = (op_r == OP_SUM) ? BW'(hv1_r ? hist_rd : '0) : BW'(b2_rd);
  assign prod = PW'(a_op) * PW'(b_op);
  assign acc_sum = acc_r + ACC_W'(prod2_r);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= last2_r ? '0 : acc_sum;
    end
  end

  // Reduce modulo the prime in five stages: fold the upper limbs by their
  // residues, estimate the quotient by a reciprocal, subtract, then at most
  // two conditional subtracts of the prime.
  assign red_p1  = red_x_r[2*VAL_W-1:VAL_W] * FOLD1[VAL_W-1:0];
  assign red_p2  = red_x_r[ACC_W-1:2*VAL_W] * FOLD2[VAL_W-1:0];
  assign red_qm  = red_y_r[YW-1:QSH] * MU[VAL_W:0];
  assign red_qp  = red_q_r * PRIME;
  assign red_rem = red_y_r - red_qp[YW-1:0];
  assign red_m1  = red_rem_r - {2'b00, PRIME};
  assign red_m2  = red_rem_r - {1'b0, PRIME, 1'b0};
  assign red_nx  = (red_rem_r >= {1'b0, PRIME, 1'b0}) ? red_m2[VAL_W-1:0]
                 : (red_rem_r >= {2'b00, PRIME}) ? red_m1[VAL_W-1:0]
                 : red_rem_r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_pipe_r <= '0;
      red_done_r <= 1'b0;
    end else begin
      red_pipe_r <= {red_pipe_r[3:0], v2_r && last2_r};
      if (red_pipe_r[4]) begin
        red_done_r <= 1'b1;
      end else if (cmd.s_write || cmd.out_load) begin
        red_done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && last2_r) begin
      red_x_r <= acc_sum;
    end
    if (red_pipe_r[0]) begin
      red_l0_r <= red_x_r[VAL_W-1:0];
      red_p1_r <= red_p1[YW-1:0];
      red_p2_r <= YW'(red_p2);
    end
    if (red_pipe_r[1]) begin
      red_y_r <= YW'(red_l0_r) + red_p1_r + red_p2_r;
    end
    if (red_pipe_r[2]) begin
      red_q_r <= VAL_W'(red_qm[2*VAL_W:QOUT]);
    end
    if (red_pipe_r[3]) begin
      red_rem_r <= red_rem[VAL_W+1:0];
    end
    if (red_pipe_r[4]) begin
      red_r <= red_nx;
    end
    if (cmd.out_load) begin
      res_r <= red_r;
    end
  end

  assign total_length = res_r;

endmodule

// ===== design/lscmp_ctrl.sv =====
// Controller: item handshake, configuration register and square-and-multiply sequencing.
module lscmp_ctrl import lscmp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ROUNDS_W-1:0] cfg_transform_rounds,
  output dp_cmd_t             cmd,
  input  dp_stat_t            stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HINC,
    ST_B_START,
    ST_B_RUN,
    ST_E_CHECK,
    ST_SQ_CHECK,
    ST_M_START,
    ST_M_ISSUE,
    ST_M_WAIT,
    ST_M_WRITE,
    ST_C_START,
    ST_C_RUN,
    ST_S_START,
    ST_S_ISSUE,
    ST_S_WAIT
  } state_t;

  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ROUNDS_W-1:0] rounds_r, rounds_nxt;
  logic [ROUNDS_W-1:0] exp_r, exp_nxt;
  logic                last_r, last_nxt;
  logic                mode_bb_r, mode_bb_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    rounds_nxt    = rounds_r;
    exp_nxt       = exp_r;
    last_nxt      = last_r;
    mode_bb_nxt   = mode_bb_r;
    cmd           = '0;
    cmd.op        = OP_BUILD;

    if (cfg_valid) begin
      rounds_nxt = cfg_transform_rounds;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_LOAD) begin
            cmd.shift_wr = 1'b1;
          end else begin
            cmd.hist_rd = 1'b1;
            last_nxt    = in_last;
            state_nxt   = ST_HINC;
          end
        end
      end
      ST_HINC: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = last_r ? ST_B_START : ST_IDLE;
      end
      ST_B_START: begin
        cmd.clr   = 1'b1;
        cmd.op    = OP_BUILD;
        exp_nxt   = rounds_r;
        state_nxt = ST_B_RUN;
      end
      ST_B_RUN: begin
        cmd.issue   = 1'b1;
        cmd.adv_ent = 1'b1;
        if (stat.ent_last) begin
          state_nxt = ST_E_CHECK;
        end
      end
      ST_E_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = ST_S_START;
        end else begin
          mode_bb_nxt = !exp_r[0];
          state_nxt   = ST_M_START;
        end
      end
      ST_SQ_CHECK: begin
        // skip the final squaring, its result is never used
        if (exp_r[ROUNDS_W-1:1] == '0) begin
          exp_nxt   = '0;
          state_nxt = ST_E_CHECK;
        end else begin
          mode_bb_nxt = 1'b1;
          state_nxt   = ST_M_START;
        end
      end
      ST_M_START: begin
        cmd.clr   = 1'b1;
        cmd.op    = OP_MUL;
        cmd.src_p = !mode_bb_r;
        state_nxt = ST_M_ISSUE;
      end
      ST_M_ISSUE: begin
        cmd.issue    = 1'b1;
        cmd.adv_k    = 1'b1;
        cmd.last_tag = stat.k_last;
        if (stat.k_last) begin
          state_nxt = ST_M_WAIT;
        end
      end
      ST_M_WAIT: begin
        if (stat.red_ready) begin
          state_nxt = ST_M_WRITE;
        end
      end
      ST_M_WRITE: begin
        cmd.s_write = 1'b1;
        cmd.adv_ent = 1'b1;
        state_nxt   = stat.ent_last ? ST_C_START : ST_M_ISSUE;
      end
      ST_C_START: begin
        cmd.clr   = 1'b1;
        cmd.op    = OP_COPY;
        cmd.dst_p = !mode_bb_r;
        state_nxt = ST_C_RUN;
      end
      ST_C_RUN: begin
        cmd.issue   = 1'b1;
        cmd.adv_ent = 1'b1;
        if (stat.ent_last) begin
          if (mode_bb_r) begin
            exp_nxt   = exp_r >> 1;
            state_nxt = ST_E_CHECK;
          end else begin
            state_nxt = ST_SQ_CHECK;
          end
        end
      end
      ST_S_START: begin
        cmd.clr   = 1'b1;
        cmd.op    = OP_SUM;
        state_nxt = ST_S_ISSUE;
      end
      ST_S_ISSUE: begin
        cmd.issue    = 1'b1;
        cmd.adv_ent  = 1'b1;
        cmd.last_tag = stat.ent_last;
        if (stat.ent_last) begin
          state_nxt = ST_S_WAIT;
        end
      end
      ST_S_WAIT: begin
        // hold until the output register is free
        if (stat.red_ready && (!out_valid_r || out_ready)) begin
          cmd.out_load  = 1'b1;
          cmd.hist_clr  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rounds_r    <= '0;
      exp_r       <= '0;
      last_r      <= 1'b0;
      mode_bb_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rounds_r    <= rounds_nxt;
      exp_r       <= exp_nxt;
      last_r      <= last_nxt;
      mode_bb_r   <= mode_bb_nxt;
    end
  end

endmodule

// ===== design/letter_shift_count_matrix_power_top.sv =====
// Top level of the letter shift count matrix power block.
//
//   channel  direction  handshake              word
//   in_      input      in_valid / in_ready    func, letter_index, shift_count, last
//   out_     output     out_valid / out_ready  total_length
//   cfg_     input      cfg_valid / cfg_ready  transform_rounds
//
// A load word is written on acceptance; a character word reads the histogram, then writes it.
// A last character then builds the matrix, runs one or two multiplies per exponent
// bit, each followed by a copy of the A*A result, and sums A*A terms; every multiply
// entry waits on the five-stage modular reducer before it is written.
// Synchronous active-low reset; no clearing pass. The input stalls while a compute
// runs; a pending result does not stall new load or character words.
module letter_shift_count_matrix_power_top import lscmp_pkg::*; #(
  parameter int ALPHABET   = 26,
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  input  logic [LETTER_W-1:0] in_letter_index,
  input  logic [CNT_IN_W-1:0] in_shift_count,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    out_total_length,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ROUNDS_W-1:0] cfg_transform_rounds
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lscmp_ctrl u_ctrl (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_last              (in_last),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_transform_rounds (cfg_transform_rounds),
    .cmd                  (cmd),
    .stat                 (stat)
  );

  lscmp_dp #(
    .ALPHABET   (ALPHABET),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_letter_index (in_letter_index),
    .in_shift_count  (in_shift_count),
    .total_length    (out_total_length)
  );

`ifndef SYNTHESIS
  a_load_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken word");

  a_swrite_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.s_write |-> stat.red_ready)
    else $error("scratch written before reduction finished");

  a_result_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.s_write || cmd.out_load) |=> !stat.red_ready)
    else $error("reduced value used twice");

  a_hist_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_wr |-> $past(cmd.hist_rd))
    else $error("histogram write without a preceding read");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the letter shift count matrix power block.
module tb_top;
  import lscmp_pkg::*;

  localparam int NLET = 26;
  localparam longint unsigned MODP = 64'd1000000007;

  typedef longint unsigned mat_t [NLET][NLET];

  typedef struct {
    bit             func;
    bit [4:0]       letter;
    bit [4:0]       count;
    bit             lst;
    bit             has_len;
    bit [VAL_W-1:0] len;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_func = FUNC_LOAD;
  logic [LETTER_W-1:0] in_letter_index = '0;
  logic [CNT_IN_W-1:0] in_shift_count = '0;
  logic                in_last = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VAL_W-1:0]    out_total_length;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ROUNDS_W-1:0] cfg_transform_rounds = '0;

  // predictor state
  bit [4:0]          shift_tbl [NLET];
  bit [31:0]         hist [NLET];
  bit [ROUNDS_W-1:0] rounds_now;

  bit [VAL_W-1:0] len_q [$];
  int             mismatches = 0;
  bit             no_gaps = 1'b0;

  letter_shift_count_matrix_power_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_letter_index(in_letter_index), .in_shift_count(in_shift_count),
    .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_total_length(out_total_length),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_transform_rounds(cfg_transform_rounds)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic mat_t mat_mul(mat_t a, mat_t b);
    mat_t r;
    longint unsigned acc;
    for (int i = 0; i < NLET; i++)
      for (int j = 0; j < NLET; j++) begin
        acc = 0;
        for (int k = 0; k < NLET; k++) acc = (acc + a[i][k] * b[k][j]) % MODP;
        r[i][j] = acc;
      end
    return r;
  endfunction

  function automatic bit [VAL_W-1:0] string_length();
    mat_t base, pw;
    bit [ROUNDS_W-1:0] e;
    longint unsigned sum;
    for (int i = 0; i < NLET; i++)
      for (int j = 0; j < NLET; j++) begin
        base[i][j] = 0;
        pw[i][j] = (i == j) ? 1 : 0;
      end
    for (int i = 0; i < NLET; i++)
      for (int k = 1; k <= shift_tbl[i]; k++) base[(i + k) % NLET][i] = 1;
    e = rounds_now;
    while (e != 0) begin
      if (e[0]) pw = mat_mul(pw, base);
      base = mat_mul(base, base);
      e = e >> 1;
    end
    sum = 0;
    for (int i = 0; i < NLET; i++)
      for (int j = 0; j < NLET; j++)
        sum = (sum + pw[i][j] * (longint'(hist[j]) % MODP)) % MODP;
    return sum[VAL_W-1:0];
  endfunction

  // Advance predictor state for one accepted word; returns 1 if a length is due.
  function automatic bit apply_word(bit f, bit [4:0] l, bit [4:0] c, bit lst,
                                    output bit [VAL_W-1:0] len);
    len = '0;
    if (f == FUNC_LOAD) begin
      if (l < NLET) shift_tbl[l] = (c > NLET) ? 5'(NLET) : c;
      return 1'b0;
    end
    if (l < NLET) hist[l] = hist[l] + 32'd1;
    if (!lst) return 1'b0;
    len = string_length();
    foreach (hist[i]) hist[i] = '0;
    return 1'b1;
  endfunction

  task automatic send_word(bit f, bit [4:0] l, bit [4:0] c, bit lst,
                           bit has_len = 1'b0, bit [VAL_W-1:0] typed_len = '0);
    bit [VAL_W-1:0] len;
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_letter_index <= l;
    in_shift_count <= c;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (apply_word(f, l, c, lst, len)) len_q.push_back(has_len ? typed_len : len);
  endtask

  task automatic drain_and_set(bit [ROUNDS_W-1:0] r);
    @(negedge clk);
    in_valid <= 1'b0;
    while (len_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_transform_rounds <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rounds_now = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One string: a few loads, then characters with last on the final one.
  task automatic send_string(int max_len);
    int n;
    repeat ($urandom_range(3)) send_word(FUNC_LOAD, 5'($urandom_range(31)),
                                         5'($urandom_range(31)), 1'($urandom));
    n = $urandom_range(max_len, 1);
    for (int i = 0; i < n; i++) begin
      bit [4:0] l;
      l = ($urandom_range(99) < 8) ? 5'($urandom_range(31, 26)) : 5'($urandom_range(25));
      send_word(FUNC_CHAR, l, 5'($urandom_range(31)), i == n - 1);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (len_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected length %0d", out_total_length);
      end else begin
        bit [VAL_W-1:0] want;
        want = len_q.pop_front();
        if (out_total_length !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("length mismatch: expected %0d, got %0d", want, out_total_length);
        end
      end
    end
  end

  always @(negedge clk) out_ready <= no_gaps || ($urandom_range(99) >= 14);

  initial begin
    #80000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    int items;
    foreach (shift_tbl[i]) shift_tbl[i] = '0;
    foreach (hist[i]) hist[i] = '0;
    rounds_now = '0;
    // after reset: zero rounds, so the result is the string length
    rows.push_back('{FUNC_CHAR, 5'd0, 5'd0, 1'b1, 1'b1, 30'd1});
    // empty string: out-of-range last character
    rows.push_back('{FUNC_CHAR, 5'd31, 5'd31, 1'b1, 1'b1, 30'd0});
    rows.push_back('{FUNC_LOAD, 5'd0, 5'd31, 1'b1, 1'b0, 30'd0});
    rows.push_back('{FUNC_LOAD, 5'd31, 5'd5, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_LOAD, 5'd25, 5'd26, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_LOAD, 5'd1, 5'd0, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_LOAD, 5'd2, 5'd27, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_CHAR, 5'd25, 5'd31, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_CHAR, 5'd0, 5'd0, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_CHAR, 5'd26, 5'd0, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_CHAR, 5'd12, 5'd0, 1'b1, 1'b1, 30'd3});
    rows.push_back('{FUNC_CHAR, 5'd2, 5'd0, 1'b0, 1'b0, 30'd0});
    rows.push_back('{FUNC_CHAR, 5'd0, 5'd0, 1'b1, 1'b0, 30'd0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_word(rows[i].func, rows[i].letter, rows[i].count, rows[i].lst,
                rows[i].has_len, rows[i].len);

    drain_and_set(31'd1);
    foreach (rows[i]) if (i >= 7) send_word(rows[i].func, rows[i].letter, rows[i].count,
                                            rows[i].lst);

    // zero rounds: bulk of the random words, results cheap
    drain_and_set(31'd0);
    items = 0;
    while (items < 1680) begin
      no_gaps = (items > 500 && items < 800);
      if ($urandom_range(99) < 10)
        send_word(1'($urandom), 5'($urandom_range(31)), 5'($urandom_range(31)),
                  1'($urandom));
      else send_string(40);
      items = items + 20;
    end
    no_gaps = 1'b0;

    drain_and_set(31'd1);
    repeat (4) send_string(10);
    drain_and_set(31'd2);
    repeat (4) send_string(10);
    drain_and_set(31'd7);
    repeat (3) send_string(10);
    drain_and_set(31'($urandom_range(12, 3)));
    repeat (3) send_string(10);
    drain_and_set(31'h7FFF_FFFF);
    send_string(6);

    @(negedge clk);
    in_valid <= 1'b0;
    while (len_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
